@@ hdl/gts_pkg.sv @@
// gait torque sequencer package: phase and queue codes, fixed constants, sine rom function
// no dependencies
package gts_pkg;

  localparam int SINE_DEPTH_DEF = 1024;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DELAY = 2'd1;
  localparam logic [1:0] PH_DRIVE = 2'd2;
  localparam logic [1:0] PH_PAUSE = 2'd3;

  localparam logic [1:0] Q_NONE = 2'd0;
  localparam logic [1:0] Q_FWD  = 2'd1;
  localparam logic [1:0] Q_REV  = 2'd2;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_FWD  = 2'd1;
  localparam logic [1:0] ACT_REV  = 2'd2;

  localparam logic [2:0] REG_DRIVE = 3'd0;
  localparam logic [2:0] REG_PAUSE = 3'd1;
  localparam logic [2:0] REG_DELAY = 3'd2;
  localparam logic [2:0] REG_KP    = 3'd3;
  localparam logic [2:0] REG_KD    = 3'd4;
  localparam logic [2:0] REG_LIMIT = 3'd5;
  localparam logic [2:0] REG_FLOOR = 3'd6;
  localparam logic [2:0] REG_SCALE = 3'd7;

  localparam logic [31:0] INC1 = 32'd18117896;
  localparam logic [31:0] OFF1 = 32'd4057086581;
  localparam logic [31:0] INC2 = 32'd54890283;
  localparam logic [31:0] OFF2 = 32'd1265279330;
  localparam logic [13:0] FORCE_GAIN = 14'd11560;
  localparam logic [10:0] AMP1 = 11'd1214;
  localparam logic [10:0] AMP2 = 11'd429;
  localparam logic [11:0] CODE_NEUTRAL = 12'd2047;
  localparam logic [11:0] CODE_MAX = 12'd4095;

  // datapath commands from the controller
  typedef struct packed {
    logic load_rom; // read both sine entries
    logic load_y;   // latch rom sums into trajectory target
    logic load_e;   // latch target and tracking error
    logic load_acc; // latch pd product sum
    logic load_pd;  // clamp and latch pd output
    logic load_out; // form the code
    logic fwd;      // direction of this drive
  } gts_cmd_t;

  // rom contents: q1.15 sine of addr/depth turns, elaborated as a constant table
  // depth is a power of two, so the turn fraction is a plain shift
  function automatic logic signed [15:0] rom_sine(longint unsigned addr, int depth);
    longint unsigned one, q, r, x, x2, t, s;
    int quad;
    one = 64'd1 << 30;
    q = addr << (32 - $clog2(depth));
    quad = int'((q >> 30) & 3);
    r = q & (one - 1);
    if (quad[0]) r = one - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = one - x2 / 72;
    t = one - ((x2 * t) >> 30) / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 32767) s = 32767;
    return (quad >= 2) ? -16'(s) : 16'(s);
  endfunction

endpackage

@@ hdl/gts_ctrl.sv @@
// gait torque sequencer controller: phase machine, tick counting, command queue
// depends on gts_pkg
module gts_ctrl
  import gts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [1:0] action,
  input  logic [7:0] drive_ticks,
  input  logic [7:0] pause_ticks,
  input  logic [7:0] delay_ticks,
  input  logic       out_free,
  output logic       busy,
  output logic       in_drive,
  output logic       out_load,
  output logic       out_drive,
  output logic [7:0] tick_count,
  output gts_cmd_t   cmd
);

  logic [1:0] phase;
  logic       fwd;
  logic [1:0] queued;
  logic [2:0] step;
  logic       work;
  logic [7:0] cnt_inc;

  assign cnt_inc   = tick_count + 8'd1;
  assign busy      = work;
  assign in_drive  = (phase == PH_DRIVE);
  assign cmd.fwd   = fwd;
  assign cmd.load_rom = work && step == 3'd0;
  assign cmd.load_y   = work && step == 3'd1;
  assign cmd.load_e   = work && step == 3'd2;
  assign cmd.load_acc = work && step == 3'd3;
  assign cmd.load_pd  = work && step == 3'd4;
  assign cmd.load_out = work && step == 3'd5;
  assign out_load  = work && step == 3'd6 && out_free;
  assign out_drive = 1'b1;

  // phase machine and drive sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      fwd <= 1'b1;
      queued <= Q_NONE;
      tick_count <= 8'd0;
      work <= 1'b0;
      step <= 3'd0;
    end else if (work) begin
      if (step == 3'd6) begin
        if (out_free) begin
          work <= 1'b0;
          step <= 3'd0;
          tick_count <= cnt_inc;
        end
      end else begin
        step <= step + 3'd1;
      end
    end else if (in_fire) begin
      if (action == ACT_FWD || action == ACT_REV) begin
        if (phase != PH_IDLE) begin
          if (action == ACT_FWD && !fwd) queued <= Q_FWD;
          if (action == ACT_REV && fwd) queued <= Q_REV;
        end else if (action == ACT_FWD) begin
          phase <= PH_DELAY;
          tick_count <= 8'd0;
        end else begin
          phase <= PH_DRIVE;
          fwd <= 1'b0;
          tick_count <= 8'd0;
        end
      end else if (action == ACT_TICK) begin
        case (phase)
          PH_DELAY: begin
            tick_count <= cnt_inc;
            if (cnt_inc >= delay_ticks) begin
              phase <= PH_DRIVE;
              fwd <= 1'b1;
              tick_count <= 8'd0;
            end
          end
          PH_PAUSE: begin
            tick_count <= cnt_inc;
            if (cnt_inc >= pause_ticks) begin
              fwd <= (queued == Q_FWD);
              queued <= Q_NONE;
              phase <= PH_DRIVE;
              tick_count <= 8'd0;
            end
          end
          PH_DRIVE: begin
            if (tick_count >= drive_ticks) begin
              phase <= (queued != Q_NONE) ? PH_PAUSE : PH_IDLE;
              tick_count <= 8'd0;
            end else begin
              work <= 1'b1;
              step <= 3'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hdl/gts_datapath.sv @@
// gait torque sequencer datapath: sine lookup, pd stage, code mapping
// depends on gts_pkg
module gts_datapath
  import gts_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_en,
  input  logic signed [15:0] sensor_force,
  input  logic [7:0]         tick_count,
  input  gts_cmd_t           cmd,
  input  logic [15:0]        kp,
  input  logic [15:0]        kd_rate,
  input  logic [14:0]        torque_limit,
  input  logic signed [15:0] torque_floor,
  input  logic [15:0]        code_scale,
  output logic [11:0]        code,
  output logic signed [15:0] desired,
  output logic signed [15:0] last_pd
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH);

  logic signed [15:0] rom [SINE_TABLE_DEPTH];
  logic signed [15:0] force_q, s1, s2;
  logic [31:0] p1, p2;
  logic signed [27:0] ysum;
  logic signed [16:0] err, last_err;
  logic signed [17:0] derr;
  logic signed [35:0] acc;
  logic signed [27:0] accr, accc, lim;
  logic signed [17:0] diff;
  logic [33:0] prod;
  logic signed [31:0] meas_p;
  logic signed [16:0] meas, ysh;

  always_comb begin
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) rom[i] = rom_sine(longint'(i), SINE_TABLE_DEPTH);
  end

  assign p1 = OFF1 + 32'(tick_count) * INC1;
  assign p2 = OFF2 + 32'(tick_count) * INC2;
  assign meas_p = force_q * $signed({1'b0, FORCE_GAIN}) + 32'sd32768;
  assign meas = 17'(meas_p >>> 16);
  assign ysh = 17'((ysum + 28'sd16384) >>> 15);
  assign derr = 18'(err) - 18'(last_err);
  assign lim = 28'($signed({1'b0, torque_limit}));
  assign accr = 28'((acc + 36'sd128) >>> 8);
  assign prod = 34'(diff) * 34'(code_scale);

  // symmetric clamp of the rounded pd sum
  always_comb begin
    accc = accr;
    if (accr > lim) accc = lim;
    else if (accr < -lim) accc = -lim;
  end

  // staged tracking and pd arithmetic
  always_ff @(posedge clk) begin
    if (sample_en) force_q <= sensor_force;
    if (cmd.load_rom) begin
      s1 <= rom[p1[31 -: AW]];
      s2 <= rom[p2[31 -: AW]];
    end
    if (cmd.load_y) begin
      ysum <= 28'(s1) * $signed({1'b0, AMP1}) + 28'(s2) * $signed({1'b0, AMP2});
    end
    if (cmd.load_e) begin
      desired <= cmd.fwd ? 16'(ysh) : 16'(-ysh);
      err <= (cmd.fwd ? ysh : -ysh) - meas;
    end
    if (cmd.load_acc) begin
      acc <= 36'(err) * $signed({1'b0, kp}) + 36'(derr) * $signed({1'b0, kd_rate});
    end
    if (cmd.load_out) begin
      if (diff <= 18'sd0) code <= 12'd0;
      else if (prod[33:16] > 18'(CODE_MAX)) code <= CODE_MAX;
      else code <= prod[27:16];
    end
    if (rst) begin
      last_err <= '0;
      last_pd <= '0;
    end else if (cmd.load_pd) begin
      last_err <= err;
      last_pd <= 16'(accc);
      diff <= 18'(accc) - 18'(torque_floor);
    end
  end

endmodule

@@ hdl/gait_torque_sequencer_pd_top.sv @@
// gait torque sequencer top: stream ports, config registers, output register
// depends on gts_pkg, gts_ctrl, gts_datapath
// Usage: s_axis beats carry the action in tuser and a force sample in tdata.
// Commands give no result; each tick (action zero) gives one m_axis beat with
// frame_valid in tuser. Action three is dropped. A drive tick runs six
// datapath steps: sine rom read, trajectory sum, tracking error, pd products,
// round and clamp, code multiply. Its beat is loaded into the output
// register after these steps, once that register is free, and the next item
// is taken only after that. Other ticks load the output register at once:
// beat in the cycle after acceptance, one item per cycle while m_axis is ready.
// s_axis_tready is low while a drive tick is at work or a result waits in
// the output register with m_axis_tready low; a stall on m_axis holds that
// register and blocks new items.
// Config writes (cfg_valid/cfg_ready, index cfg_addr) apply at once and are
// meant for idle. Synchronous reset loads register defaults, idle phase,
// forward direction, an empty queue and a zero pd history.
module gait_torque_sequencer_pd_top
  import gts_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sensor_force[15:0]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // torque_code[11:0], desired[27:12], pd_torque[43:28]
  output logic        m_axis_tuser,   // frame_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  logic [7:0] drive_ticks, pause_ticks, delay_ticks;
  logic [15:0] kp, kd_rate, code_scale;
  logic [14:0] torque_limit;
  logic signed [15:0] torque_floor;
  logic in_fire, busy, in_drive, out_load, out_drive, out_free;
  logic [7:0] tick_count;
  gts_cmd_t cmd;
  logic [11:0] code;
  logic signed [15:0] desired, last_pd;
  logic [1:0] action;
  logic drive_tick, end_tick, tick_now;

  assign action = s_axis_tuser;
  assign cfg_ready = 1'b1;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !busy && out_free;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_ticks <= 8'd125; pause_ticks <= 8'd20; delay_ticks <= 8'd60;
      kp <= 16'd128; kd_rate <= 16'd1024; torque_limit <= 15'd2560;
      torque_floor <= -16'sd2560; code_scale <= 16'd52429;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_DRIVE: drive_ticks <= cfg_data[7:0];
        REG_PAUSE: pause_ticks <= cfg_data[7:0];
        REG_DELAY: delay_ticks <= cfg_data[7:0];
        REG_KP:    kp <= cfg_data;
        REG_KD:    kd_rate <= cfg_data;
        REG_LIMIT: torque_limit <= cfg_data[14:0];
        REG_FLOOR: torque_floor <= cfg_data;
        REG_SCALE: code_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  gts_ctrl u_ctrl (
    .clk, .rst, .in_fire, .action, .drive_ticks, .pause_ticks,
    .delay_ticks, .out_free, .busy, .in_drive, .out_load, .out_drive, .tick_count, .cmd
  );

  gts_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
    .clk, .rst, .sample_en(in_fire), .sensor_force(s_axis_tdata),
    .tick_count, .cmd, .kp, .kd_rate, .torque_limit, .torque_floor,
    .code_scale, .code, .desired, .last_pd
  );

  // classify the tick against the controller's phase
  assign tick_now = in_fire && action == ACT_TICK;
  assign drive_tick = tick_now && in_drive;
  assign end_tick = drive_tick && tick_count >= drive_ticks;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load && out_drive) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tuser <= 1'b1;
      m_axis_tdata <= {4'd0, last_pd, desired, code};
    end else if (tick_now && (!drive_tick || end_tick)) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tuser <= end_tick;
      m_axis_tdata <= {4'd0, last_pd, 16'd0, end_tick ? CODE_NEUTRAL : 12'd0};
    end else if (m_axis_tvalid && m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule
